[hw/rtl/pac_pkg.sv]
// ----------------------------------------------------------------------------
// pac_pkg: shared types and constants for the pressure altitude converter
// Layer tables, fixed-point formats, elaboration-time helpers and a rounding shift.
// ----------------------------------------------------------------------------
package pac_pkg;

  // Default parameter values
  localparam int LayersDef   = 8;
  localparam int FracBitsDef = 8;

  // Field widths
  localparam int PW   = 25;  // pressure sample
  localparam int HW   = 25;  // height in cm
  localparam int LW   = 3;   // layer index
  localparam int FW   = 2;   // range flag
  localparam int LOGF = 20;  // log2 fraction bits
  localparam int DW   = 28;  // log difference / exponent argument
  localparam int MW   = 31;  // Q30 mantissa
  localparam int KW   = 38;  // final scale constant
  localparam int VW   = 40;  // final multiplicand
  localparam int PRW  = 72;  // full product
  localparam int SW   = 46;  // summed height before clamping

  // Range flag codes
  localparam logic [FW-1:0] FLAG_NORMAL = 2'd0;
  localparam logic [FW-1:0] FLAG_SAT    = 2'd1;
  localparam logic [FW-1:0] FLAG_ZERO   = 2'd2;

  localparam logic signed [HW-1:0] H_MIN = -25'sd100000;
  localparam logic signed [HW-1:0] H_MAX = 25'sd10000000;

  localparam logic signed [63:0] RG_Q24      = 64'sd491090248;
  localparam logic signed [63:0] CM_LOG2_Q16 = 64'sd132967899;

  // Layer base pressures in Q16 pascals
  localparam logic [33:0] BASE_P [8] = '{
    34'd7136870400, 34'd1483210752, 34'd358803046, 34'd56886559,
    34'd7268598, 34'd4390912, 34'd259287, 34'd24471
  };

  // Layer base heights in cm
  localparam logic signed [HW-1:0] BASE_H [8] = '{
    -25'sd61000, 25'sd1100000, 25'sd2000000, 25'sd3200000,
    25'sd4700000, 25'sd5100000, 25'sd7100000, 25'sd8490000
  };

  // Isothermal layers (zero lapse rate)
  localparam logic [7:0] ISO = 8'b1001_0010;

  // Exponent scale -a*R/g in Q24 for gradient layers
  localparam logic signed [22:0] EXP_E [8] = '{
    23'((64'sd6500 * RG_Q24) / 64'sd1000000),
    23'sd0,
    23'(-((64'sd1000 * RG_Q24) / 64'sd1000000)),
    23'(-((64'sd2800 * RG_Q24) / 64'sd1000000)),
    23'sd0,
    23'((64'sd2800 * RG_Q24) / 64'sd1000000),
    23'((64'sd2000 * RG_Q24) / 64'sd1000000),
    23'sd0
  };

  // Final scale: Tb/(-a) in cm for gradient layers, -(R*Tb/g)*ln2 in Q16 for isothermal
  localparam logic signed [KW-1:0] SCALE_K [8] = '{
    38'((64'sd292150 * 64'sd100000) / 64'sd6500),
    38'(-((64'sd216650 * CM_LOG2_Q16) / 64'sd1000)),
    38'(-((64'sd216650 * 64'sd100000) / 64'sd1000)),
    38'(-((64'sd228650 * 64'sd100000) / 64'sd2800)),
    38'(-((64'sd270650 * CM_LOG2_Q16) / 64'sd1000)),
    38'((64'sd270650 * 64'sd100000) / 64'sd2800),
    38'((64'sd214650 * 64'sd100000) / 64'sd2000),
    38'(-((64'sd186870 * CM_LOG2_Q16) / 64'sd1000))
  };

  // Pipeline side information
  typedef struct packed {
    logic          zero;
    logic          iso;
    logic          ovf;
    logic [LW-1:0] layer;
  } ctl_t;

  typedef struct packed {
    ctl_t                ctl;
    logic signed [7:0]   expo;
    logic [MW-1:0]       m;
    logic [LOGF-1:0]     frac;
  } log_t;

  typedef struct packed {
    ctl_t                ctl;
    logic signed [DW-1:0] x;
    logic [MW-1:0]       y;
  } exp_t;

  // Integer square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Q30 root 2^(2^-k), elaboration only
  function automatic logic [63:0] root_q30(input int k);
    logic [63:0] root;
    root = 64'd2 << 30;
    for (int j = 1; j <= k; j++) begin
      root = isqrt64(root << 30);
    end
    return root;
  endfunction

  // log2(v / 2^fb) in Q20 for a constant, elaboration only
  function automatic longint log2c(input logic [63:0] v, input int fb);
    int          top;
    logic [63:0] m;
    longint      frac;
    top = 0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) top = i;
    end
    m = (top > 30) ? (v >> (top - 30)) : (v << (30 - top));
    frac = 0;
    for (int k = 0; k < LOGF; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(top - fb) * (longint'(1) << LOGF) + frac;
  endfunction

  // log2 of each base pressure in Q20
  localparam logic signed [DW-1:0] LOG_BASE [8] = '{
    28'(log2c(64'(BASE_P[0]), 16)), 28'(log2c(64'(BASE_P[1]), 16)),
    28'(log2c(64'(BASE_P[2]), 16)), 28'(log2c(64'(BASE_P[3]), 16)),
    28'(log2c(64'(BASE_P[4]), 16)), 28'(log2c(64'(BASE_P[5]), 16)),
    28'(log2c(64'(BASE_P[6]), 16)), 28'(log2c(64'(BASE_P[7]), 16))
  };

  // Shift right by s, rounding half away from zero
  function automatic logic signed [PRW-1:0] round_sh(input logic signed [PRW-1:0] v,
                                                     input logic [5:0] s);
    logic [PRW-1:0] mag;
    mag = v[PRW-1] ? PRW'(-v) : PRW'(v);
    mag = (mag + (PRW'(1) << (s - 6'd1))) >> s;
    return v[PRW-1] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

[hw/rtl/pac_log_cell.sv]
// ----------------------------------------------------------------------------
// pac_log_cell: one log2 fraction bit
// Squares the Q30 mantissa, renormalizes and shifts out one fraction bit.
// ----------------------------------------------------------------------------
module pac_log_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pac_pkg::log_t  data_i,
  output logic           valid_o,
  output pac_pkg::log_t  data_o
);

  logic [61:0]             sq;
  logic [31:0]             sq_hi;
  pac_pkg::log_t           data_d;
  logic                    valid_q;
  pac_pkg::log_t           data_q;

  // Square and take one bit
  always_comb begin
    sq     = 62'(data_i.m) * 62'(data_i.m);
    sq_hi  = sq[61:30];
    data_d = data_i;
    data_d.m    = sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
    data_d.frac = {data_i.frac[pac_pkg::LOGF-2:0], sq_hi[31]};
  end

  // Advance the stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hw/rtl/pac_exp_cell.sv]
// ----------------------------------------------------------------------------
// pac_exp_cell: one exponent fraction bit
// Multiplies the Q30 result by a fixed root of two when its bit is set.
// ----------------------------------------------------------------------------
module pac_exp_cell #(
  parameter int CELL_IDX = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pac_pkg::exp_t  data_i,
  output logic           valid_o,
  output pac_pkg::exp_t  data_o
);

  localparam logic [pac_pkg::MW-1:0] ROOT = pac_pkg::MW'(pac_pkg::root_q30(CELL_IDX));
  localparam int BIT_IDX = pac_pkg::LOGF - CELL_IDX;

  logic [61:0]   pr;
  pac_pkg::exp_t data_d;
  logic          valid_q;
  pac_pkg::exp_t data_q;

  // Apply the root for this bit
  always_comb begin
    pr     = 62'(data_i.y) * 62'(ROOT);
    data_d = data_i;
    if (data_i.x[BIT_IDX]) begin
      data_d.y = pr[60:30];
    end
  end

  // Advance the stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hw/rtl/pressure_altitude_converter.sv]
// ----------------------------------------------------------------------------
// pressure_altitude_converter: standard-atmosphere pressure to height
// Selects the layer, takes log2 of the sample, applies the layer formula.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle unless held; the cell chain advances as one.
// The chain holds while a result waits at the output and the sink is not ready.
// Depth is set by 20 log2 squaring cells and 20 root-multiply cells.
// Reset clears all stage valid bits; no result is pending after reset.
module pressure_altitude_converter #(
  parameter int LAYERS    = pac_pkg::LayersDef,
  parameter int FRAC_BITS = pac_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [24:0] pressure_q8, [31:25] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [24:0] height_cm, [27:25] layer, [31:28] zero
  output logic [1:0]  m_axis_tuser    // [1:0] range_flag
);

  localparam int NCELL = pac_pkg::LOGF;

  logic en;

  // Front stage
  logic [pac_pkg::PW-1:0] p;
  logic [49:0]            lhs;
  logic [pac_pkg::LW-1:0] lay;
  logic [4:0]             top;
  pac_pkg::log_t          front_d;

  // Chain links
  logic          log_vld [NCELL+1];
  pac_pkg::log_t log_dat [NCELL+1];
  logic          exp_vld [NCELL+1];
  pac_pkg::exp_t exp_dat [NCELL+1];

  // Back stages
  logic                          d_vld_q;
  pac_pkg::ctl_t                 d_ctl_q;
  logic signed [pac_pkg::DW-1:0] d_q;
  logic                          x_vld_q;
  pac_pkg::ctl_t                 x_ctl_q;
  logic signed [pac_pkg::DW-1:0] xd_q;
  logic signed [50:0]            prod_q;
  logic signed [pac_pkg::DW-1:0] x_d;

  logic signed [7:0]             n;
  logic [7:0]                    namt;
  logic [37:0]                   ys;
  logic signed [pac_pkg::VW-1:0] v_d;
  pac_pkg::ctl_t                 v_ctl_d;
  logic                          v_vld_q;
  pac_pkg::ctl_t                 v_ctl_q;
  logic signed [pac_pkg::VW-1:0] v_q;

  logic                          m1_vld_q;
  pac_pkg::ctl_t                 m1_ctl_q;
  logic signed [58:0]            pl_q;
  logic signed [57:0]            ph_q;

  logic                           m2_vld_q;
  pac_pkg::ctl_t                  m2_ctl_q;
  logic signed [pac_pkg::PRW-1:0] pr_q;

  logic                          r_vld_q;
  pac_pkg::ctl_t                 r_ctl_q;
  logic signed [pac_pkg::SW-1:0] h_q;
  logic signed [pac_pkg::SW-1:0] r_d;

  logic                          out_vld_q;
  logic signed [pac_pkg::HW-1:0] out_h_q;
  logic [pac_pkg::LW-1:0]        out_l_q;
  logic [pac_pkg::FW-1:0]        out_f_q;
  logic signed [pac_pkg::HW-1:0] h_out;
  logic [pac_pkg::FW-1:0]        f_out;

  // Whole chain advances when the output register is free or taken
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Select the layer and normalize the sample to a Q30 mantissa
  always_comb begin
    p   = s_axis_tdata[pac_pkg::PW-1:0];
    lhs = 50'(p) << 16;
    lay = pac_pkg::LW'(LAYERS - 1);
    for (int i = LAYERS - 2; i >= 0; i--) begin
      if (lhs > (50'(pac_pkg::BASE_P[i+1]) << FRAC_BITS)) lay = pac_pkg::LW'(i);
    end
    top = '0;
    for (int i = 0; i < pac_pkg::PW; i++) begin
      if (p[i]) top = 5'(i);
    end
    front_d.ctl.zero  = (p == '0);
    front_d.ctl.iso   = pac_pkg::ISO[lay];
    front_d.ctl.ovf   = 1'b0;
    front_d.ctl.layer = lay;
    front_d.expo      = $signed({3'b000, top}) - 8'(FRAC_BITS);
    front_d.m         = pac_pkg::MW'(31'(p) << (5'd30 - top));
    front_d.frac      = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_vld[0] <= 1'b0;
    end else if (en) begin
      log_vld[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      log_dat[0] <= front_d;
    end
  end

  // log2 chain
  for (genvar k = 0; k < NCELL; k++) begin : g_log
    pac_log_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (log_vld[k]),
      .data_i  (log_dat[k]),
      .valid_o (log_vld[k+1]),
      .data_o  (log_dat[k+1])
    );
  end

  // Subtract the base log
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
      x_vld_q <= 1'b0;
      exp_vld[0] <= 1'b0;
    end else if (en) begin
      d_vld_q <= log_vld[NCELL];
      x_vld_q <= d_vld_q;
      exp_vld[0] <= x_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_ctl_q <= log_dat[NCELL].ctl;
      d_q     <= $signed({log_dat[NCELL].expo, log_dat[NCELL].frac})
                 - pac_pkg::LOG_BASE[log_dat[NCELL].ctl.layer];
      // Scale the log difference by the exponent factor
      x_ctl_q <= d_ctl_q;
      xd_q    <= d_q;
      prod_q  <= pac_pkg::EXP_E[d_ctl_q.layer] * 51'(d_q);
      // Round to the exponent argument
      exp_dat[0] <= '{ctl: x_ctl_q, x: x_d, y: pac_pkg::MW'(1) << 30};
    end
  end

  assign x_d = x_ctl_q.iso ? xd_q
                           : pac_pkg::DW'(pac_pkg::round_sh(pac_pkg::PRW'(prod_q), 6'd24));

  // Exponential chain
  for (genvar k = 0; k < NCELL; k++) begin : g_exp
    pac_exp_cell #(.CELL_IDX(k + 1)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (exp_vld[k]),
      .data_i  (exp_dat[k]),
      .valid_o (exp_vld[k+1]),
      .data_o  (exp_dat[k+1])
    );
  end

  // Apply the integer part of the exponent and form the multiplicand
  always_comb begin
    n    = exp_dat[NCELL].x[pac_pkg::DW-1:pac_pkg::LOGF];
    namt = 8'(-n);
    if (!n[7]) begin
      ys = 38'(exp_dat[NCELL].y) << n[2:0];
    end else if (namt >= 8'd31) begin
      ys = '0;
    end else begin
      ys = 38'(exp_dat[NCELL].y) >> namt[4:0];
    end
    if (exp_dat[NCELL].ctl.iso) begin
      v_d = pac_pkg::VW'(exp_dat[NCELL].x);
    end else begin
      v_d = (pac_pkg::VW'(1) << 30) - $signed({2'b00, ys});
    end
    v_ctl_d     = exp_dat[NCELL].ctl;
    v_ctl_d.ovf = !exp_dat[NCELL].ctl.iso && (n > 8'sd6);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_vld_q   <= 1'b0;
      m1_vld_q  <= 1'b0;
      m2_vld_q  <= 1'b0;
      r_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v_vld_q   <= exp_vld[NCELL];
      m1_vld_q  <= v_vld_q;
      m2_vld_q  <= m1_vld_q;
      r_vld_q   <= m2_vld_q;
      out_vld_q <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_ctl_q     <= v_ctl_d;
      v_q         <= v_d;
      // Partial products of the final scaling
      m1_ctl_q <= v_ctl_q;
      pl_q     <= pac_pkg::SCALE_K[v_ctl_q.layer] * $signed({1'b0, v_q[19:0]});
      ph_q     <= pac_pkg::SCALE_K[v_ctl_q.layer] * $signed(v_q[39:20]);
      // Combine the partial products
      m2_ctl_q <= m1_ctl_q;
      pr_q     <= (pac_pkg::PRW'(ph_q) <<< 20) + pac_pkg::PRW'(pl_q);
      // Round and add the base height
      r_ctl_q  <= m2_ctl_q;
      h_q      <= pac_pkg::SW'(pac_pkg::BASE_H[m2_ctl_q.layer]) + r_d;
      // Clamp into the output register
      out_h_q  <= h_out;
      out_l_q  <= r_ctl_q.layer;
      out_f_q  <= f_out;
    end
  end

  assign r_d = pac_pkg::SW'(pac_pkg::round_sh(pr_q, m2_ctl_q.iso ? 6'd36 : 6'd30));

  // Saturate and flag
  always_comb begin
    f_out = pac_pkg::FLAG_NORMAL;
    h_out = pac_pkg::HW'(h_q);
    if (r_ctl_q.zero) begin
      h_out = pac_pkg::H_MAX;
      f_out = pac_pkg::FLAG_ZERO;
    end else if (r_ctl_q.ovf) begin
      h_out = (pac_pkg::SCALE_K[r_ctl_q.layer] > 0) ? pac_pkg::H_MIN : pac_pkg::H_MAX;
      f_out = pac_pkg::FLAG_SAT;
    end else if (h_q > pac_pkg::SW'(pac_pkg::H_MAX)) begin
      h_out = pac_pkg::H_MAX;
      f_out = pac_pkg::FLAG_SAT;
    end else if (h_q < pac_pkg::SW'(pac_pkg::H_MIN)) begin
      h_out = pac_pkg::H_MIN;
      f_out = pac_pkg::FLAG_SAT;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_l_q, out_h_q};
  assign m_axis_tuser  = out_f_q;

endmodule

[hw/rtl/pac_chk.sv]
// ----------------------------------------------------------------------------
// pac_chk: port checks for the pressure altitude converter
// Watches the result stream for consistent flags, heights and holding.
// ----------------------------------------------------------------------------
module pac_chk #(
  parameter int LAYERS = pac_pkg::LayersDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic signed [pac_pkg::HW-1:0] h;
  logic [pac_pkg::LW-1:0]        lay;

  assign h   = $signed(m_axis_tdata[24:0]);
  assign lay = m_axis_tdata[27:25];

  // Zero pressure reports the top height in the top layer
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == pac_pkg::FLAG_ZERO)
      |-> (h == pac_pkg::H_MAX) && (lay == pac_pkg::LW'(LAYERS - 1)))
    else $error("zero-pressure result malformed");

  // Saturated heights sit on a bound
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == pac_pkg::FLAG_SAT)
      |-> (h == pac_pkg::H_MAX) || (h == pac_pkg::H_MIN))
    else $error("saturated height off bound");

  // Flag is a known code, height in range, layer in use
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == pac_pkg::FLAG_NORMAL) ||
                       (m_axis_tuser == pac_pkg::FLAG_SAT) ||
                       (m_axis_tuser == pac_pkg::FLAG_ZERO)) &&
                      (h <= pac_pkg::H_MAX) && (h >= pac_pkg::H_MIN) &&
                      (lay <= pac_pkg::LW'(LAYERS - 1)))
    else $error("result out of range");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
      |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled transaction changed");

endmodule

bind pressure_altitude_converter pac_chk #(.LAYERS(LAYERS)) u_pac_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
